// ===== hdl/beacon_peak_lock_search_core_assert.svh =====
// Assertion macros for the beacon peak-lock search core checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BEACON_PEAK_LOCK_SEARCH_CORE_ASSERT_SVH
`define BEACON_PEAK_LOCK_SEARCH_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define BPLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BPLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bpls_pkg.sv =====
// Shared types, codes and constants of the beacon peak-lock search core.
// No dependencies; the datapath, controller, top and checker import this package.
`timescale 1ns / 1ps

package bpls_pkg;

  localparam int WINDOW_LEN_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int OP_W       = 2;
  localparam int PHASE_W    = 3;
  localparam int MOTOR_W    = 2;
  localparam int OFFSET_W   = 10;
  localparam int TICK_W     = 16;
  localparam int POWER_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [OFFSET_W-1:0] LOCK_OFFSET_RST  = 10'd10;
  localparam logic [TICK_W-1:0]   ROTATION_RST     = 16'd5000;
  localparam logic [TICK_W-1:0]   LOCK_DELAY_RST   = 16'd250;
  localparam logic [TICK_W-1:0]   BACKUP_RST       = 16'd500;
  localparam logic [TICK_W-1:0]   STOP_DELAY_RST   = 16'd250;
  localparam logic [POWER_W-1:0]  TURN_POWER_RST   = 10'd500;
  localparam logic [POWER_W-1:0]  DRIVE_POWER_RST  = 10'd700;

  typedef enum logic [OP_W-1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_SWEEP   = 3'd1,
    PH_WAIT    = 3'd2,
    PH_TURN    = 3'd3,
    PH_BACKUP  = 3'd4,
    PH_STOPPED = 3'd5
  } phase_t;

  typedef enum logic [MOTOR_W-1:0] {
    MOTOR_STOP       = 2'd0,
    MOTOR_TURN_RIGHT = 2'd1,
    MOTOR_BACKWARD   = 2'd2
  } motor_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOCK_OFFSET  = 3'd0,
    REG_ROTATION     = 3'd1,
    REG_LOCK_DELAY   = 3'd2,
    REG_BACKUP       = 3'd3,
    REG_STOP_DELAY   = 3'd4,
    REG_TURN_POWER   = 3'd5,
    REG_DRIVE_POWER  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DECODE = 3'd1,
    ST_PUSH   = 3'd2,
    ST_DIVIDE = 3'd3,
    ST_FINISH = 3'd4
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic ring_read;
    logic push;
    logic apply_item;
    logic apply_push;
    logic load_out;
  } bpls_cmd_t;

  typedef struct packed {
    logic is_push;
    logic div_done;
  } bpls_status_t;

endpackage

// ===== hdl/bpls_div.sv =====
// Restoring divider, one quotient bit per cycle, for the moving average.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module bpls_div #(
  parameter int SUM_W  = 13,
  parameter int FILL_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [FILL_W-1:0] divisor,
  output logic [SUM_W-1:0]  quotient,
  output logic              done
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  work_r, work_nxt;
  logic [FILL_W-1:0] rem_r, rem_nxt;
  logic [FILL_W-1:0] dvs_r, dvs_nxt;
  logic [FILL_W:0]   trial;
  logic [FILL_W:0]   diff;
  logic              ge;

  assign trial = {rem_r, work_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(SUM_W);
      work_nxt = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      work_nxt = {work_r[SUM_W-2:0], ge};
      rem_nxt  = ge ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign quotient = work_r;
  assign done     = done_r;

endmodule

// ===== hdl/bpls_datapath.sv =====
// Datapath: configuration registers, sample ring, average, peak, threshold,
// search phase and countdown, output registers. Uses bpls_pkg and bpls_div.
`timescale 1ns / 1ps

module bpls_datapath import bpls_pkg::*; #(
  parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [OP_W-1:0]        in_operation,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  bpls_cmd_t              cmd,
  output bpls_status_t           status,
  output logic [PHASE_W-1:0]     out_phase,
  output logic [MOTOR_W-1:0]     out_motor_mode,
  output logic [POWER_W-1:0]     out_motor_power,
  output logic [SAMPLE_BITS-1:0] out_average_level,
  output logic [SAMPLE_BITS-1:0] out_peak_level,
  output logic [SAMPLE_BITS-1:0] out_lock_threshold,
  output logic                   out_locked
);

  localparam int POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int CMP_W  = (SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W;

  logic [OFFSET_W-1:0] lock_offset_r;
  logic [TICK_W-1:0]   rotation_r, lock_delay_r, backup_r, stop_delay_r;
  logic [POWER_W-1:0]  turn_power_r, drive_power_r;

  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0] ring_rd_r;

  logic [OP_W-1:0]        op_r, op_nxt;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic [SAMPLE_BITS-1:0] rot_peak_r, rot_peak_nxt;
  logic [SAMPLE_BITS-1:0] thr_r, thr_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [TICK_W-1:0]      cd_r, cd_nxt;
  logic                   locked_r, locked_nxt;

  logic [PHASE_W-1:0]     o_phase_r;
  logic [MOTOR_W-1:0]     o_mode_r;
  logic [POWER_W-1:0]     o_power_r;
  logic [SAMPLE_BITS-1:0] o_avg_r, o_peak_r, o_thr_r;
  logic                   o_locked_r;

  logic                   full;
  logic [SUM_W-1:0]       quotient;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] q_avg;

  function automatic logic [SAMPLE_BITS-1:0] thr_of(input logic [SAMPLE_BITS-1:0] pk,
                                                    input logic [OFFSET_W-1:0] off);
    logic [CMP_W-1:0] pk_e;
    logic [CMP_W-1:0] off_e;
    pk_e  = CMP_W'(pk);
    off_e = CMP_W'(off);
    return (pk_e > off_e) ? SAMPLE_BITS'(pk_e - off_e) : '0;
  endfunction

  assign full  = (fill_r == FILL_W'(WINDOW_LEN));
  assign q_avg = quotient[SAMPLE_BITS-1:0];

  assign status.is_push  = (op_r == OP_SAMPLE) && (phase_r == PH_SWEEP || phase_r == PH_TURN);
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_offset_r <= LOCK_OFFSET_RST;
      rotation_r    <= ROTATION_RST;
      lock_delay_r  <= LOCK_DELAY_RST;
      backup_r      <= BACKUP_RST;
      stop_delay_r  <= STOP_DELAY_RST;
      turn_power_r  <= TURN_POWER_RST;
      drive_power_r <= DRIVE_POWER_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LOCK_OFFSET: lock_offset_r <= cfg_data[OFFSET_W-1:0];
        REG_ROTATION:    rotation_r    <= cfg_data[TICK_W-1:0];
        REG_LOCK_DELAY:  lock_delay_r  <= cfg_data[TICK_W-1:0];
        REG_BACKUP:      backup_r      <= cfg_data[TICK_W-1:0];
        REG_STOP_DELAY:  stop_delay_r  <= cfg_data[TICK_W-1:0];
        REG_TURN_POWER:  turn_power_r  <= cfg_data[POWER_W-1:0];
        REG_DRIVE_POWER: drive_power_r <= cfg_data[POWER_W-1:0];
        default: ;
      endcase
    end
  end

  // ring entries past the fill count never enter the sum, so no clearing is needed
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring_mem[pos_r] <= sample_r;
    end
    if (cmd.ring_read) begin
      ring_rd_r <= ring_mem[pos_r];
    end
  end

  bpls_div #(
    .SUM_W  (SUM_W),
    .FILL_W (FILL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.push),
    .dividend (sum_nxt),
    .divisor  (fill_nxt),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    logic                   do_clear;
    logic [SAMPLE_BITS-1:0] pk_sel;
    do_clear     = 1'b0;
    pk_sel       = (rot_peak_r != '0) ? rot_peak_r : peak_r;
    op_nxt       = op_r;
    sample_nxt   = sample_r;
    pos_nxt      = pos_r;
    fill_nxt     = fill_r;
    sum_nxt      = sum_r;
    avg_nxt      = avg_r;
    peak_nxt     = peak_r;
    rot_peak_nxt = rot_peak_r;
    thr_nxt      = thr_r;
    phase_nxt    = phase_r;
    cd_nxt       = cd_r;
    locked_nxt   = locked_r;

    if (cmd.capture) begin
      op_nxt     = in_operation;
      sample_nxt = in_sample;
      locked_nxt = 1'b0;
    end

    if (cmd.apply_item) begin
      case (op_r)
        OP_START: begin
          do_clear  = 1'b1;
          peak_nxt  = '0;
          phase_nxt = PH_SWEEP;
          cd_nxt    = rotation_r;
        end
        OP_TICK: begin
          if (phase_r != PH_IDLE) begin
            if (cd_r <= TICK_W'(1)) begin
              cd_nxt = '0;
              case (phase_r)
                PH_SWEEP: begin
                  do_clear  = 1'b1;
                  thr_nxt   = thr_of(peak_r, lock_offset_r);
                  phase_nxt = PH_WAIT;
                  cd_nxt    = lock_delay_r;
                end
                PH_WAIT: begin
                  rot_peak_nxt = '0;
                  do_clear     = 1'b1;
                  phase_nxt    = PH_TURN;
                  cd_nxt       = rotation_r;
                end
                PH_TURN: begin
                  peak_nxt     = pk_sel;
                  thr_nxt      = thr_of(pk_sel, lock_offset_r);
                  rot_peak_nxt = '0;
                  do_clear     = 1'b1;
                  cd_nxt       = rotation_r;
                end
                PH_BACKUP: begin
                  phase_nxt = PH_STOPPED;
                  cd_nxt    = stop_delay_r;
                end
                default: ;
              endcase
            end else begin
              cd_nxt = cd_r - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd.push) begin
      fill_nxt = full ? fill_r : fill_r + 1'b1;
      sum_nxt  = sum_r - (full ? SUM_W'(ring_rd_r) : '0) + SUM_W'(sample_r);
      pos_nxt  = (pos_r == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_r + 1'b1;
    end

    if (cmd.apply_push) begin
      avg_nxt = q_avg;
      if (phase_r == PH_SWEEP) begin
        if (q_avg > peak_r) begin
          peak_nxt = q_avg;
        end
      end else begin
        if (q_avg > rot_peak_r) begin
          rot_peak_nxt = q_avg;
        end
        if (q_avg >= thr_r) begin
          locked_nxt = 1'b1;
          phase_nxt  = PH_BACKUP;
          cd_nxt     = backup_r;
        end
      end
    end

    if (do_clear) begin
      pos_nxt  = '0;
      fill_nxt = '0;
      sum_nxt  = '0;
      avg_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      fill_r     <= '0;
      sum_r      <= '0;
      avg_r      <= '0;
      peak_r     <= '0;
      rot_peak_r <= '0;
      thr_r      <= '0;
      phase_r    <= PH_IDLE;
      cd_r       <= '0;
      locked_r   <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      fill_r     <= fill_nxt;
      sum_r      <= sum_nxt;
      avg_r      <= avg_nxt;
      peak_r     <= peak_nxt;
      rot_peak_r <= rot_peak_nxt;
      thr_r      <= thr_nxt;
      phase_r    <= phase_nxt;
      cd_r       <= cd_nxt;
      locked_r   <= locked_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    sample_r <= sample_nxt;
    if (cmd.load_out) begin
      o_phase_r  <= phase_r;
      o_avg_r    <= avg_r;
      o_peak_r   <= peak_r;
      o_thr_r    <= thr_r;
      o_locked_r <= locked_r;
      case (phase_r)
        PH_SWEEP, PH_TURN: begin
          o_mode_r  <= MOTOR_TURN_RIGHT;
          o_power_r <= turn_power_r;
        end
        PH_BACKUP: begin
          o_mode_r  <= MOTOR_BACKWARD;
          o_power_r <= drive_power_r;
        end
        default: begin
          o_mode_r  <= MOTOR_STOP;
          o_power_r <= '0;
        end
      endcase
    end
  end

  assign out_phase          = o_phase_r;
  assign out_motor_mode     = o_mode_r;
  assign out_motor_power    = o_power_r;
  assign out_average_level  = o_avg_r;
  assign out_peak_level     = o_peak_r;
  assign out_lock_threshold = o_thr_r;
  assign out_locked         = o_locked_r;

endmodule

// ===== hdl/bpls_ctrl.sv =====
// Controller: sequences each push through decode, ring update, divide and
// result transfer. Uses bpls_pkg; drives the datapath by command struct.
`timescale 1ns / 1ps

module bpls_ctrl import bpls_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  bpls_status_t status,
  output bpls_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.is_push) begin
          cmd.ring_read = 1'b1;
          state_nxt     = ST_PUSH;
        end else begin
          cmd.apply_item = 1'b1;
          state_nxt      = ST_FINISH;
        end
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          cmd.apply_push = 1'b1;
          state_nxt      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/beacon_peak_lock_search_core.sv =====
// Top level of the beacon peak-lock search core: controller plus datapath.
// Uses bpls_pkg, bpls_ctrl and bpls_datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | in_valid / in_stall  | in_operation, in_sample
//   result   | out_valid / out_stall| out_phase, out_motor_mode, out_motor_power,
//            |                      | out_average_level, out_peak_level,
//            |                      | out_lock_threshold, out_locked
//   config   | cfg_wr_en            | cfg_index, cfg_data
//
// A sample in sweep or lock turn goes through the ring update and the one-bit-per-cycle
// restoring divider for the average before its result transfers. Start, tick and
// ignored items skip both. One item is in work at a time.
// Reset is synchronous; the fill count stands in for clearing the ring.
// A stalled result holds in the output register; the next item is taken and waits
// for that register before its own result transfers.
`timescale 1ns / 1ps

module beacon_peak_lock_search_core import bpls_pkg::*; #(
  parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OP_W-1:0]        in_operation,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PHASE_W-1:0]     out_phase,
  output logic [MOTOR_W-1:0]     out_motor_mode,
  output logic [POWER_W-1:0]     out_motor_power,
  output logic [SAMPLE_BITS-1:0] out_average_level,
  output logic [SAMPLE_BITS-1:0] out_peak_level,
  output logic [SAMPLE_BITS-1:0] out_lock_threshold,
  output logic                   out_locked
);

  bpls_cmd_t    cmd;
  bpls_status_t status;

  bpls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bpls_datapath #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_operation       (in_operation),
    .in_sample          (in_sample),
    .cmd                (cmd),
    .status             (status),
    .out_phase          (out_phase),
    .out_motor_mode     (out_motor_mode),
    .out_motor_power    (out_motor_power),
    .out_average_level  (out_average_level),
    .out_peak_level     (out_peak_level),
    .out_lock_threshold (out_lock_threshold),
    .out_locked         (out_locked)
  );

endmodule

// ===== hdl/bpls_checker.sv =====
// Port-level checker for the beacon peak-lock search core, bound to the top.
// Uses bpls_pkg and beacon_peak_lock_search_core_assert.svh.
`timescale 1ns / 1ps
`include "beacon_peak_lock_search_core_assert.svh"

module bpls_checker import bpls_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [PHASE_W-1:0] out_phase,
  input logic [MOTOR_W-1:0] out_motor_mode,
  input logic [POWER_W-1:0] out_motor_power,
  input logic               out_locked
);

  `BPLS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")
  `BPLS_ASSERT_NOW(a_lock_backup, out_valid && out_locked, out_phase == PH_BACKUP, "lock without backup")
  `BPLS_ASSERT_NOW(a_turn_mode, out_valid && (out_phase == PH_SWEEP || out_phase == PH_TURN), out_motor_mode == MOTOR_TURN_RIGHT, "turn phase without turn mode")
  `BPLS_ASSERT_NOW(a_stop_power, out_valid && out_motor_mode == MOTOR_STOP, out_motor_power == '0, "power while stopped")

endmodule

bind beacon_peak_lock_search_core bpls_checker u_bpls_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_phase       (out_phase),
  .out_motor_mode  (out_motor_mode),
  .out_motor_power (out_motor_power),
  .out_locked      (out_locked)
);
